FILE: rtl/talc_pkg.sv
// Shared types and constants of the tag access lock controller.
`timescale 1ns / 1ps

package talc_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_FRAME_LENGTH    = 3'd0;
   localparam logic [2:0] CSR_ID_OFFSET       = 3'd1;
   localparam logic [2:0] CSR_KEY_A           = 3'd2;
   localparam logic [2:0] CSR_KEY_B           = 3'd3;
   localparam logic [2:0] CSR_SUCCESS_HOLD    = 3'd4;
   localparam logic [2:0] CSR_FAIL_HOLD       = 3'd5;
   localparam logic [2:0] CSR_COUNTDOWN_START = 3'd6;

   // register reset values
   localparam logic [6:0]  FRAME_LENGTH_RESET    = 7'd13;
   localparam logic [5:0]  ID_OFFSET_RESET       = 6'd8;
   localparam logic [31:0] KEY_A_RESET           = 32'h4445_4446;
   localparam logic [31:0] KEY_B_RESET           = 32'h4144_4544;
   localparam logic [7:0]  SUCCESS_HOLD_RESET    = 8'd5;
   localparam logic [7:0]  FAIL_HOLD_RESET       = 8'd3;
   localparam logic [3:0]  COUNTDOWN_START_RESET = 4'd5;

   localparam logic [6:0] FRAME_LENGTH_MIN = 7'd1;
   localparam logic [6:0] FRAME_LENGTH_MAX = 7'd64;
   localparam logic [3:0] DIGIT_MIN        = 4'd1;
   localparam logic [3:0] DIGIT_MAX        = 4'd9;
   localparam logic [7:0] HOLD_SATURATE    = 8'd255;

   // request kinds
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // lock state codes on the result channel
   localparam logic [1:0] LOCK_CODE_LOCKED  = 2'd0;
   localparam logic [1:0] LOCK_CODE_DENIED  = 2'd1;
   localparam logic [1:0] LOCK_CODE_GRANTED = 2'd2;

   // indicator lamp nibbles
   localparam logic [3:0] LAMP_LOCKED  = 4'h2;
   localparam logic [3:0] LAMP_DENIED  = 4'h8;
   localparam logic [3:0] LAMP_GRANTED = 4'h5;

   typedef enum logic [2:0] {
      LOCK_LOCKED  = 3'b001,
      LOCK_DENIED  = 3'b010,
      LOCK_GRANTED = 3'b100
   } lock_mode_type;

   typedef enum logic [2:0] {
      VERDICT_IDLE    = 3'b001,
      VERDICT_GRANTED = 3'b010,
      VERDICT_DENIED  = 3'b100
   } verdict_type;

   typedef enum logic [1:0] {
      DISP_WAIT  = 2'b01,
      DISP_COUNT = 2'b10
   } disp_mode_type;

   // frame capture logic to lock unit
   typedef struct packed {
      logic tick;
      logic frame_done;
      logic id_matched;
   } lock_ctl_type;

   // lock unit to top: lock state and display after the current request, verdict_idle before it
   typedef struct packed {
      logic       verdict_idle;
      logic [1:0] lock_state;
      logic [3:0] indicator;
      logic       display_blank;
      logic [3:0] display_digit;
   } lock_status_type;

   typedef struct packed {
      logic [1:0] lock_state;
      logic [3:0] indicator;
      logic       display_blank;
      logic [3:0] display_digit;
      logic       frame_done;
      logic       id_matched;
   } result_type;

endpackage

FILE: rtl/talc_lock.sv
// Lock mode machine, hold counter, verdict and countdown display.
`timescale 1ns / 1ps

module talc_lock (
   input  logic                      clock,
   input  logic                      reset,
   input  talc_pkg::lock_ctl_type    ctl,
   input  logic [7:0]                success_hold,
   input  logic [7:0]                fail_hold,
   input  logic [3:0]                countdown_start,
   output talc_pkg::lock_status_type status
);

   talc_pkg::lock_mode_type lock_mode_ff, lock_mode_in;
   talc_pkg::verdict_type   verdict_ff, verdict_in;
   talc_pkg::disp_mode_type disp_mode_ff, disp_mode_in;
   logic [7:0]              hold_count_ff, hold_count_in;
   logic [3:0]              countdown_ff, countdown_in;
   logic [3:0]              start_digit;

   always_comb begin
      if (countdown_start < talc_pkg::DIGIT_MIN) begin
         start_digit = talc_pkg::DIGIT_MIN;
      end else if (countdown_start > talc_pkg::DIGIT_MAX) begin
         start_digit = talc_pkg::DIGIT_MAX;
      end else begin
         start_digit = countdown_start;
      end
   end

   always_comb begin
      lock_mode_in  = lock_mode_ff;
      verdict_in    = verdict_ff;
      disp_mode_in  = disp_mode_ff;
      hold_count_in = hold_count_ff;
      countdown_in  = countdown_ff;
      if (ctl.tick) begin
         // lock mode first
         unique case (lock_mode_ff)
            talc_pkg::LOCK_DENIED: begin
               if (!(hold_count_ff < fail_hold)) lock_mode_in = talc_pkg::LOCK_LOCKED;
            end
            talc_pkg::LOCK_GRANTED: begin
               if (!(hold_count_ff < success_hold)) lock_mode_in = talc_pkg::LOCK_LOCKED;
            end
            default: begin
               lock_mode_in = talc_pkg::LOCK_LOCKED;
               if (verdict_ff == talc_pkg::VERDICT_GRANTED) begin
                  lock_mode_in = talc_pkg::LOCK_GRANTED;
               end else if (verdict_ff == talc_pkg::VERDICT_DENIED) begin
                  lock_mode_in = talc_pkg::LOCK_DENIED;
               end
            end
         endcase
         if (lock_mode_in == talc_pkg::LOCK_LOCKED) begin
            hold_count_in = '0;
            verdict_in    = talc_pkg::VERDICT_IDLE;
         end else if (hold_count_ff < talc_pkg::HOLD_SATURATE) begin
            hold_count_in = hold_count_ff + 8'd1;
         end
         // display second, sees the verdict left by the lock machine
         unique case (disp_mode_ff)
            talc_pkg::DISP_COUNT: begin
               if (countdown_ff == '0) begin
                  countdown_in = start_digit;
                  disp_mode_in = talc_pkg::DISP_WAIT;
               end
            end
            default: begin
               disp_mode_in = talc_pkg::DISP_WAIT;
               if (verdict_in == talc_pkg::VERDICT_GRANTED) disp_mode_in = talc_pkg::DISP_COUNT;
            end
         endcase
         if (disp_mode_in == talc_pkg::DISP_COUNT && countdown_in != '0) begin
            countdown_in = countdown_in - 4'd1;
         end
      end else if (ctl.frame_done) begin
         verdict_in = ctl.id_matched ? talc_pkg::VERDICT_GRANTED : talc_pkg::VERDICT_DENIED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_mode_ff  <= talc_pkg::LOCK_LOCKED;
         verdict_ff    <= talc_pkg::VERDICT_IDLE;
         disp_mode_ff  <= talc_pkg::DISP_WAIT;
         hold_count_ff <= '0;
         countdown_ff  <= talc_pkg::COUNTDOWN_START_RESET;
      end else begin
         lock_mode_ff  <= lock_mode_in;
         verdict_ff    <= verdict_in;
         disp_mode_ff  <= disp_mode_in;
         hold_count_ff <= hold_count_in;
         countdown_ff  <= countdown_in;
      end
   end

   always_comb begin
      status.verdict_idle = (verdict_ff == talc_pkg::VERDICT_IDLE);
      unique case (lock_mode_in)
         talc_pkg::LOCK_DENIED: begin
            status.lock_state = talc_pkg::LOCK_CODE_DENIED;
            status.indicator  = talc_pkg::LAMP_DENIED;
         end
         talc_pkg::LOCK_GRANTED: begin
            status.lock_state = talc_pkg::LOCK_CODE_GRANTED;
            status.indicator  = talc_pkg::LAMP_GRANTED;
         end
         default: begin
            status.lock_state = talc_pkg::LOCK_CODE_LOCKED;
            status.indicator  = talc_pkg::LAMP_LOCKED;
         end
      endcase
      if (disp_mode_in == talc_pkg::DISP_COUNT) begin
         status.display_blank = 1'b0;
         status.display_digit = countdown_in + 4'd1;
      end else begin
         status.display_blank = 1'b1;
         status.display_digit = '0;
      end
   end

`ifndef SYNTHESIS
   a_hold_zero_when_locked: assert property (@(posedge clock) disable iff (reset)
      lock_mode_ff == talc_pkg::LOCK_LOCKED |-> hold_count_ff == '0)
      else $error("hold count nonzero while locked");

   a_verdict_kept_while_open: assert property (@(posedge clock) disable iff (reset)
      lock_mode_ff != talc_pkg::LOCK_LOCKED |-> verdict_ff != talc_pkg::VERDICT_IDLE)
      else $error("lock open with idle verdict");

   a_countdown_in_range: assert property (@(posedge clock) disable iff (reset)
      countdown_ff <= talc_pkg::DIGIT_MAX)
      else $error("countdown out of range");
`endif

endmodule

FILE: rtl/tag_access_lock_controller.sv
// Top level of the tag access lock controller: registers, frame capture, result buffer.
// Usage:
//   Request channel (req_valid, req_stall, req_func, req_rx_byte): each request is a
//   reader byte (func 0) or a one-second tick (func 1). A request is taken at a clock
//   edge with req_valid high and req_stall low.
//   Response channel (rsp_valid, rsp_stall, rsp_*): exactly one response per request,
//   in order, taken at an edge with rsp_valid high and rsp_stall low.
//   Register port (csr_valid, csr_ready, csr_index, csr_wdata): always ready; write only
//   while no request is outstanding.
// Response: a taken request's result is registered in the response or skid register.
// Throughput: one request per cycle while req_stall is low; byte capture, key compare
//   and the lock/display update are combinational, in front of the response register.
// Stall: a two-entry output buffer (response register plus skid register) absorbs one
//   extra request; req_stall rises when the skid register holds a response and drops
//   the cycle after the receiver takes one.
// Reset (synchronous, active high): registers return to their defaults, the lock is
//   locked, the display blank, the frame position zero and both output entries empty.
`timescale 1ns / 1ps

module tag_access_lock_controller #(
   parameter int ID_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_lock_state,
   output logic [3:0]  rsp_indicator,
   output logic        rsp_display_blank,
   output logic [3:0]  rsp_display_digit,
   output logic        rsp_frame_done,
   output logic        rsp_id_matched,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int ID_W  = 8 * ID_BYTES;
   localparam int KEY_W = (ID_W > 32) ? ID_W : 32;

   logic [6:0]  frame_length_ff;
   logic [5:0]  id_offset_ff;
   logic [31:0] key_a_ff, key_b_ff;
   logic [7:0]  success_hold_ff, fail_hold_ff;
   logic [3:0]  countdown_start_ff;

   logic [5:0]      byte_index_ff, byte_index_in;
   logic [ID_W-1:0] id_capture_ff, id_capture_in;

   logic                      req_accept, rsp_take, byte_accept, in_id, frame_done;
   logic [6:0]                frame_len, pos_next, id_end;
   logic [ID_W+7:0]           id_join;
   logic [ID_W-1:0]           id_new;
   logic [KEY_W-1:0]          key_a_ext, key_b_ext;
   logic                      id_matched;
   talc_pkg::lock_ctl_type    lock_ctl;
   talc_pkg::lock_status_type lock_status;
   talc_pkg::result_type      result;

   logic                 out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   talc_pkg::result_type out_data_ff, out_data_in, skid_data_ff, skid_data_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff    <= talc_pkg::FRAME_LENGTH_RESET;
         id_offset_ff       <= talc_pkg::ID_OFFSET_RESET;
         key_a_ff           <= talc_pkg::KEY_A_RESET;
         key_b_ff           <= talc_pkg::KEY_B_RESET;
         success_hold_ff    <= talc_pkg::SUCCESS_HOLD_RESET;
         fail_hold_ff       <= talc_pkg::FAIL_HOLD_RESET;
         countdown_start_ff <= talc_pkg::COUNTDOWN_START_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            talc_pkg::CSR_FRAME_LENGTH:    frame_length_ff    <= csr_wdata[6:0];
            talc_pkg::CSR_ID_OFFSET:       id_offset_ff       <= csr_wdata[5:0];
            talc_pkg::CSR_KEY_A:           key_a_ff           <= csr_wdata;
            talc_pkg::CSR_KEY_B:           key_b_ff           <= csr_wdata;
            talc_pkg::CSR_SUCCESS_HOLD:    success_hold_ff    <= csr_wdata[7:0];
            talc_pkg::CSR_FAIL_HOLD:       fail_hold_ff       <= csr_wdata[7:0];
            talc_pkg::CSR_COUNTDOWN_START: countdown_start_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // request handshake
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   // frame capture and key compare
   assign byte_accept = req_accept && (req_func == talc_pkg::FUNC_BYTE) &&
                        lock_status.verdict_idle;

   always_comb begin
      if (frame_length_ff < talc_pkg::FRAME_LENGTH_MIN) begin
         frame_len = talc_pkg::FRAME_LENGTH_MIN;
      end else if (frame_length_ff > talc_pkg::FRAME_LENGTH_MAX) begin
         frame_len = talc_pkg::FRAME_LENGTH_MAX;
      end else begin
         frame_len = frame_length_ff;
      end
   end

   assign pos_next   = {1'b0, byte_index_ff} + 7'd1;
   assign id_end     = {1'b0, id_offset_ff} + 7'(ID_BYTES);
   assign in_id      = (byte_index_ff >= id_offset_ff) && ({1'b0, byte_index_ff} < id_end);
   assign id_join    = {id_capture_ff, req_rx_byte};
   assign id_new     = in_id ? id_join[ID_W-1:0] : id_capture_ff;
   assign frame_done = byte_accept && (pos_next >= frame_len);
   assign key_a_ext  = KEY_W'(key_a_ff);
   assign key_b_ext  = KEY_W'(key_b_ff);
   assign id_matched = frame_done && ((id_new == key_a_ext[ID_W-1:0]) ||
                                      (id_new == key_b_ext[ID_W-1:0]));

   always_comb begin
      byte_index_in = byte_index_ff;
      id_capture_in = id_capture_ff;
      if (byte_accept) begin
         if (frame_done) begin
            byte_index_in = '0;
            id_capture_in = '0;
         end else begin
            byte_index_in = pos_next[5:0];
            id_capture_in = id_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         id_capture_ff <= '0;
      end else begin
         byte_index_ff <= byte_index_in;
         id_capture_ff <= id_capture_in;
      end
   end

   assign lock_ctl.tick       = req_accept && (req_func == talc_pkg::FUNC_TICK);
   assign lock_ctl.frame_done = frame_done;
   assign lock_ctl.id_matched = id_matched;

   talc_lock u_lock (
      .clock           (clock),
      .reset           (reset),
      .ctl             (lock_ctl),
      .success_hold    (success_hold_ff),
      .fail_hold       (fail_hold_ff),
      .countdown_start (countdown_start_ff),
      .status          (lock_status)
   );

   always_comb begin
      result.lock_state    = lock_status.lock_state;
      result.indicator     = lock_status.indicator;
      result.display_blank = lock_status.display_blank;
      result.display_digit = lock_status.display_digit;
      result.frame_done    = frame_done;
      result.id_matched    = id_matched;
   end

   // response register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_take) begin
         out_valid_in = skid_valid_ff;
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end
      if (req_accept) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_lock_state    = out_data_ff.lock_state;
   assign rsp_indicator     = out_data_ff.indicator;
   assign rsp_display_blank = out_data_ff.display_blank;
   assign rsp_display_digit = out_data_ff.display_digit;
   assign rsp_frame_done    = out_data_ff.frame_done;
   assign rsp_id_matched    = out_data_ff.id_matched;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty response register");

   a_match_needs_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.id_matched |-> out_data_ff.frame_done)
      else $error("match reported without a completed frame");

   a_blank_digit_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.display_blank |-> out_data_ff.display_digit == '0)
      else $error("digit shown on blank display");

   a_skid_frees: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> !skid_valid_ff)
      else $error("skid entry not drained after response taken");
`endif

endmodule
